@@ rtl/core/gcb_pkg.sv @@
// Shared types and constants for the gamma-correct color blend.
`timescale 1ns / 1ps

package gcb_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int WEIGHT_BITS  = 9;
    localparam int WEIGHT_FRAC  = 8;
    localparam int LANES_IN     = 6;
    localparam int LANES_OUT    = 3;

    localparam int unsigned CMAX = (1 << CHANNEL_BITS) - 1;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << WEIGHT_FRAC);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] start_r;
        logic [CHANNEL_BITS-1:0] start_g;
        logic [CHANNEL_BITS-1:0] start_b;
        logic [CHANNEL_BITS-1:0] end_r;
        logic [CHANNEL_BITS-1:0] end_g;
        logic [CHANNEL_BITS-1:0] end_b;
        logic [WEIGHT_BITS-1:0]  mix_weight;
    } t_blend_in;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_r;
        logic [CHANNEL_BITS-1:0] out_g;
        logic [CHANNEL_BITS-1:0] out_b;
    } t_blend_out;

endpackage

@@ rtl/core/gamma_correct_color_blend.sv @@
// Gamma-correct blend of two RGB colors, fully pipelined.
`timescale 1ns / 1ps

// Takes one pixel pair per clock (busy never rises) and returns each blended
// pixel through the pipeline below, with o_done high for one cycle as it leaves.
// The receiver cannot stall, so no beat is ever held back. Most of the
// pipeline is the square-root pipeline, which resolves one root bit per stage
// (FRACTION_BITS + 1 stages); the remaining ten stages hold the normalize table,
// the cubic, the weighted mix, the re-encode and the output saturation. A zero
// blended value gives a zero channel.
module gamma_correct_color_blend
    import gcb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_blend_in  i_pix,
    output logic       o_done,
    output t_blend_out o_pix
);

    localparam int FW  = FRACTION_BITS;
    localparam int XW  = FW + 1;            // Q1.F value up to 1.0
    localparam int PW  = 2 * XW;            // product of two Q1.F values
    localparam int SW  = PW + 1;
    localparam int MW  = XW + WEIGHT_BITS;  // value times weight
    localparam int YSW = MW + 1;
    localparam int NW  = FW + XW;           // sqrt radicand y << F
    localparam int TW  = NW + 1;
    localparam int RW  = PW - FW;
    localparam int OW  = RW + CHANNEL_BITS;
    localparam int HW  = OW - FW;
    localparam int NQ  = FW + 2;            // sqrt pipe entries

    localparam longint unsigned ONE   = 64'd1 << FW;
    localparam longint unsigned K08   = (64'd8 * ONE + 64'd5) / 64'd10;
    localparam longint unsigned K02   = (64'd2 * ONE + 64'd5) / 64'd10;
    localparam longint unsigned K1138 = (64'd1138 * ONE + 64'd500) / 64'd1000;
    localparam longint unsigned K0138 = (64'd138 * ONE + 64'd500) / 64'd1000;

    localparam logic [XW-1:0] K08_V   = K08[XW-1:0];
    localparam logic [XW-1:0] K02_V   = K02[XW-1:0];
    localparam logic [XW-1:0] K1138_V = K1138[XW-1:0];
    localparam logic [XW-1:0] K0138_V = K0138[XW-1:0];

    // channel code to Q1.F: floor(c * ONE / CMAX)
    logic [XW-1:0] w_xtab [2**CHANNEL_BITS];

    for (genvar gi = 0; gi < 2**CHANNEL_BITS; gi++) begin : g_xtab
        localparam longint unsigned XV = (64'(gi) * ONE) / CMAX;
        assign w_xtab[gi] = XV[XW-1:0];
    end

    logic                    w_accept;
    logic [CHANNEL_BITS-1:0] w_in_c [LANES_IN];

    logic [5:0]             r_v;
    logic [WEIGHT_BITS-1:0] r_w [5];

    logic [XW-1:0] r_s1_x   [LANES_IN];
    logic [XW-1:0] r_s2_x   [LANES_IN];
    logic [XW-1:0] r_s2_x2  [LANES_IN];
    logic [XW-1:0] r_s3_x3  [LANES_IN];
    logic [PW-1:0] r_s3_p08 [LANES_IN];
    logic [PW-1:0] r_s4_p08 [LANES_IN];
    logic [PW-1:0] r_s4_p02 [LANES_IN];
    logic [XW-1:0] r_s5_lin [LANES_IN];
    logic [MW-1:0] r_s6_ms  [LANES_OUT];
    logic [MW-1:0] r_s6_me  [LANES_OUT];

    logic [PW-1:0]  w_s2_p   [LANES_IN];
    logic [PW-1:0]  w_s3_p3  [LANES_IN];
    logic [PW-1:0]  w_s3_p08 [LANES_IN];
    logic [PW-1:0]  w_s4_p02 [LANES_IN];
    logic [SW-1:0]  w_s5_sum [LANES_IN];
    logic [MW-1:0]  w_s6_ms  [LANES_OUT];
    logic [MW-1:0]  w_s6_me  [LANES_OUT];
    logic [YSW-1:0] w_s7_sum [LANES_OUT];

    logic          r_q_v    [NQ];
    logic [NW-1:0] r_q_rem  [NQ][LANES_OUT];
    logic [XW-1:0] r_q_root [NQ][LANES_OUT];
    logic [XW-1:0] r_q_y    [NQ][LANES_OUT];

    logic                    r_va;
    logic                    r_vb;
    logic                    r_done;
    logic [PW-1:0]           r_a_pos [LANES_OUT];
    logic [PW-1:0]           r_a_neg [LANES_OUT];
    logic [RW-1:0]           r_b_r   [LANES_OUT];
    logic [CHANNEL_BITS-1:0] r_o     [LANES_OUT];

    logic [PW-1:0]           w_a_pos [LANES_OUT];
    logic [PW-1:0]           w_a_neg [LANES_OUT];
    logic [PW-1:0]           w_b_dif [LANES_OUT];
    logic [OW-1:0]           w_c_p   [LANES_OUT];
    logic [HW-1:0]           w_c_hi  [LANES_OUT];
    logic [CHANNEL_BITS-1:0] n_o     [LANES_OUT];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_in_c[0] = i_pix.start_r;
    assign w_in_c[1] = i_pix.start_g;
    assign w_in_c[2] = i_pix.start_b;
    assign w_in_c[3] = i_pix.end_r;
    assign w_in_c[4] = i_pix.end_g;
    assign w_in_c[5] = i_pix.end_b;

    always_comb begin
        for (int i = 0; i < LANES_IN; i++) begin
            w_s2_p[i]   = PW'(r_s1_x[i]) * PW'(r_s1_x[i]);
            w_s3_p3[i]  = PW'(r_s2_x2[i]) * PW'(r_s2_x[i]);
            w_s3_p08[i] = PW'(K08_V) * PW'(r_s2_x2[i]);
            w_s4_p02[i] = PW'(K02_V) * PW'(r_s3_x3[i]);
            w_s5_sum[i] = SW'(r_s4_p08[i]) + SW'(r_s4_p02[i]);
        end
        for (int c = 0; c < LANES_OUT; c++) begin
            w_s6_ms[c]  = MW'(r_s5_lin[c]) * MW'(r_w[4]);
            w_s6_me[c]  = MW'(r_s5_lin[c + LANES_OUT]) * MW'(WEIGHT_ONE - r_w[4]);
            w_s7_sum[c] = YSW'(r_s6_ms[c]) + YSW'(r_s6_me[c]);
        end
    end

    // control: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_q_v[0] <= 1'b0;
            r_va     <= 1'b0;
            r_vb     <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_v      <= {r_v[4:0], w_accept};
            r_q_v[0] <= r_v[5];
            r_va     <= r_q_v[NQ-1];
            r_vb     <= r_va;
            r_done   <= r_vb;
        end
    end

    // front stages: normalize, cube, mix
    always_ff @(posedge i_clk) begin
        r_w[0] <= (i_pix.mix_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_pix.mix_weight;
        for (int k = 1; k < 5; k++) begin
            r_w[k] <= r_w[k-1];
        end
        for (int i = 0; i < LANES_IN; i++) begin
            r_s1_x[i]   <= w_xtab[w_in_c[i]];
            r_s2_x[i]   <= r_s1_x[i];
            r_s2_x2[i]  <= w_s2_p[i][FW +: XW];
            r_s3_x3[i]  <= w_s3_p3[i][FW +: XW];
            r_s3_p08[i] <= w_s3_p08[i];
            r_s4_p08[i] <= r_s3_p08[i];
            r_s4_p02[i] <= w_s4_p02[i];
            r_s5_lin[i] <= w_s5_sum[i][FW +: XW];
        end
        for (int c = 0; c < LANES_OUT; c++) begin
            r_s6_ms[c]     <= w_s6_ms[c];
            r_s6_me[c]     <= w_s6_me[c];
            r_q_y[0][c]    <= w_s7_sum[c][WEIGHT_FRAC +: XW];
            r_q_rem[0][c]  <= {w_s7_sum[c][WEIGHT_FRAC +: XW], {FW{1'b0}}};
            r_q_root[0][c] <= '0;
        end
    end

    // square root of y << F, one root bit per stage, MSB first
    for (genvar gj = 0; gj <= FW; gj++) begin : g_sqrt
        localparam int BK = FW - gj;

        logic [TW-1:0] w_trial [LANES_OUT];
        logic          w_ge    [LANES_OUT];
        logic [NW-1:0] n_rem   [LANES_OUT];
        logic [XW-1:0] n_root  [LANES_OUT];

        always_comb begin
            for (int c = 0; c < LANES_OUT; c++) begin
                // (root + 2^k)^2 - root^2
                w_trial[c] = (TW'(r_q_root[gj][c]) << (BK + 1)) + (TW'(1) << (2 * BK));
                w_ge[c]    = TW'(r_q_rem[gj][c]) >= w_trial[c];
                n_rem[c]   = w_ge[c] ? (r_q_rem[gj][c] - w_trial[c][NW-1:0])
                                     : r_q_rem[gj][c];
                n_root[c]  = w_ge[c] ? (r_q_root[gj][c] | (XW'(1) << BK))
                                     : r_q_root[gj][c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[gj+1] <= 1'b0;
            end else begin
                r_q_v[gj+1] <= r_q_v[gj];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int c = 0; c < LANES_OUT; c++) begin
                r_q_rem[gj+1][c]  <= n_rem[c];
                r_q_root[gj+1][c] <= n_root[c];
                r_q_y[gj+1][c]    <= r_q_y[gj][c];
            end
        end
    end

    // re-encode: 1.138*sqrt(y) - 0.138*y, then scale to channel range
    always_comb begin
        for (int c = 0; c < LANES_OUT; c++) begin
            w_a_pos[c] = PW'(K1138_V) * PW'(r_q_root[NQ-1][c]);
            w_a_neg[c] = PW'(K0138_V) * PW'(r_q_y[NQ-1][c]);
            w_b_dif[c] = r_a_pos[c] - r_a_neg[c];
            // r * CMAX as a shift and subtract
            w_c_p[c]   = (OW'(r_b_r[c]) << CHANNEL_BITS) - OW'(r_b_r[c]);
            w_c_hi[c]  = w_c_p[c][OW-1:FW];
            n_o[c]     = (w_c_hi[c] > HW'(CMAX)) ? CHANNEL_BITS'(CMAX)
                                                 : w_c_hi[c][CHANNEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < LANES_OUT; c++) begin
            r_a_pos[c] <= w_a_pos[c];
            r_a_neg[c] <= w_a_neg[c];
            r_b_r[c]   <= (r_a_pos[c] > r_a_neg[c]) ? w_b_dif[c][PW-1:FW] : '0;
            r_o[c]     <= n_o[c];
        end
    end

    assign o_done      = r_done;
    assign o_pix.out_r = r_o[0];
    assign o_pix.out_g = r_o[1];
    assign o_pix.out_b = r_o[2];

endmodule

@@ rtl/core/gcb_checker.sv @@
// Port-level assertions for the gamma-correct color blend, bound to the top level.
`timescale 1ns / 1ps

module gcb_checker
    import gcb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input t_blend_in  i_pix,
    input logic       o_done,
    input t_blend_out o_pix
);

    localparam int LAT = FRACTION_BITS + 11;

    // block never refuses a beat
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted beat produced no result at the pipeline latency");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without an accepted beat");

    // black on both sides blends to black whatever the weight
    a_black_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_pix.start_r == 0 && i_pix.start_g == 0 &&
         i_pix.start_b == 0 && i_pix.end_r == 0 && i_pix.end_g == 0 &&
         i_pix.end_b == 0)
        |-> ##LAT (o_pix.out_r == 0 && o_pix.out_g == 0 && o_pix.out_b == 0))
        else $error("zero blend gave a nonzero channel");

endmodule

bind gamma_correct_color_blend gcb_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_gcb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_pix   (i_pix),
    .o_done  (o_done),
    .o_pix   (o_pix)
);
